// File: rtl/dlbp_pkg.sv
package dlbp_pkg;

  localparam int unsigned ACC_W      = 41;
  localparam int unsigned LEFT_W     = 40;
  localparam int unsigned RECLEN_W   = 27;
  localparam int unsigned BPP_W      = 4;
  localparam int unsigned NREC_W     = 10;
  localparam int unsigned PROD1_W    = RECLEN_W + BPP_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [7:0]       HASH_CHAR  = 8'h23;
  localparam logic [3:0]       MAX_DIGITS = 4'd15;
  localparam logic [4:0]       HEX_BASE   = 5'd16;
  localparam logic [ACC_W-1:0] ACC_SAT    = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [ACC_W-1:0] ACC_BAD    = {ACC_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_ARMED        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_LEN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MULTI_RECORD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_RECORDS  = 3'd4;

  typedef enum logic [2:0] {
    ST_DROP   = 3'd0,
    ST_HEADER = 3'd1,
    ST_DATA   = 3'd2,
    ST_LAST   = 3'd3,
    ST_REJECT = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    PH_HUNT  = 4'b0001,
    PH_COUNT = 4'b0010,
    PH_LEN   = 4'b0100,
    PH_DATA  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic             armed;
    logic [ACC_W-1:0] expect_len;
  } dlbp_cfg_t;

  // HEX_BASE marks a byte that is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = HEX_BASE;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 5'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 5'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 5'(c - 8'h41 + 8'd10);
    end
    return v;
  endfunction

endpackage

// File: rtl/dlbp_cfg.sv
module dlbp_cfg
  import dlbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output dlbp_cfg_t             cfg,
  output logic                  busy
);

  logic                armed;
  logic [RECLEN_W-1:0] record_length;
  logic [BPP_W-1:0]    bytes_per_point;
  logic                multi_record;
  logic [NREC_W-1:0]   num_records;
  logic [PROD1_W-1:0]  prod1;
  logic [ACC_W-1:0]    expect_len;
  logic [NREC_W-1:0]   frames;
  logic                settle;

  always_ff @(posedge clk) begin
    if (rst) begin
      armed           <= 1'b0;
      record_length   <= RECLEN_W'(1);
      bytes_per_point <= BPP_W'(1);
      multi_record    <= 1'b0;
      num_records     <= NREC_W'(1);
    end else if (wr_en) begin
      case (wr_index)
        REG_ARMED:        armed           <= wr_data[0];
        REG_RECORD_LEN:   record_length   <= wr_data[RECLEN_W-1:0];
        REG_BYTES_PER_PT: bytes_per_point <= wr_data[BPP_W-1:0];
        REG_MULTI_RECORD: multi_record    <= wr_data[0];
        REG_NUM_RECORDS:  num_records     <= wr_data[NREC_W-1:0];
        default: ;
      endcase
    end
  end

  assign frames = multi_record ? num_records : NREC_W'(1);

  // Two-stage product: prod1, then expect_len.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod1      <= PROD1_W'(1);
      expect_len <= ACC_W'(1);
    end else begin
      prod1      <= PROD1_W'(record_length) * PROD1_W'(bytes_per_point);
      expect_len <= ACC_W'(prod1) * ACC_W'(frames);
    end
  end

  // Hold the input in the write cycle and the one after, so the first byte
  // that can reach the compare sees the settled product
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= 1'b0;
    end else begin
      settle <= wr_en;
    end
  end

  assign busy = wr_en || settle;

  assign cfg.armed      = armed;
  assign cfg.expect_len = expect_len;

endmodule

// File: rtl/dlbp_parser.sv
module dlbp_parser
  import dlbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dlbp_cfg_t  cfg,
  input  logic       cfg_hold,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output status_t    status,
  output logic [7:0] payload_byte
);

  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              advance;

  phase_t            phase, phase_next;
  logic [3:0]        digits_left, digits_left_next;
  logic [ACC_W-1:0]  length_acc, length_acc_next;
  logic [LEFT_W-1:0] payload_left, payload_left_next;
  status_t           status_next;
  logic [7:0]        data_next;

  logic [4:0]        nb;
  logic              is_dec;
  logic [ACC_W+3:0]  acc_x10;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = (s1_valid && !advance) || cfg_hold;

  // Input register: hold while the result register is blocked
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance || !s1_valid) begin
      s1_valid <= in_valid && !in_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte <= rx_byte;
    end
  end

  assign nb      = hex_value(s1_byte);
  assign is_dec  = (s1_byte >= 8'h30) && (s1_byte <= 8'h39);
  assign acc_x10 = ({4'b0, length_acc} << 3) + ({4'b0, length_acc} << 1)
                 + (ACC_W+4)'(s1_byte[3:0]);

  always_comb begin
    phase_next        = phase;
    digits_left_next  = digits_left;
    length_acc_next   = length_acc;
    payload_left_next = payload_left;
    status_next       = ST_DROP;
    data_next         = 8'h00;
    if (!cfg.armed) begin
      phase_next        = PH_HUNT;
      digits_left_next  = 4'd0;
      length_acc_next   = '0;
      payload_left_next = '0;
    end else begin
      case (phase)
        PH_HUNT: begin
          if (s1_byte == HASH_CHAR) begin
            phase_next  = PH_COUNT;
            status_next = ST_HEADER;
          end
        end
        PH_COUNT: begin
          if (nb != 5'd0 && nb <= {1'b0, MAX_DIGITS}) begin
            digits_left_next = nb[3:0];
            length_acc_next  = '0;
            phase_next       = PH_LEN;
            status_next      = ST_HEADER;
          end else begin
            phase_next        = PH_HUNT;
            digits_left_next  = 4'd0;
            length_acc_next   = '0;
            payload_left_next = '0;
            status_next       = ST_REJECT;
          end
        end
        PH_LEN: begin
          // Saturate at ACC_SAT; a non-decimal digit poisons the length
          if (is_dec) begin
            if (length_acc != ACC_BAD) begin
              if (length_acc >= ACC_SAT || acc_x10 > (ACC_W+4)'(ACC_SAT)) begin
                length_acc_next = ACC_SAT;
              end else begin
                length_acc_next = acc_x10[ACC_W-1:0];
              end
            end
          end else begin
            length_acc_next = ACC_BAD;
          end
          status_next = ST_HEADER;
          if (digits_left > 4'd1) begin
            digits_left_next = digits_left - 4'd1;
          end else if (cfg.expect_len != '0 && length_acc_next == cfg.expect_len) begin
            payload_left_next = cfg.expect_len[LEFT_W-1:0];
            digits_left_next  = 4'd0;
            phase_next        = PH_DATA;
          end else begin
            phase_next        = PH_HUNT;
            digits_left_next  = 4'd0;
            length_acc_next   = '0;
            payload_left_next = '0;
            status_next       = ST_REJECT;
          end
        end
        PH_DATA: begin
          data_next = s1_byte;
          if (payload_left > LEFT_W'(1)) begin
            payload_left_next = payload_left - LEFT_W'(1);
            status_next       = ST_DATA;
          end else begin
            phase_next        = PH_HUNT;
            digits_left_next  = 4'd0;
            length_acc_next   = '0;
            payload_left_next = '0;
            status_next       = ST_LAST;
          end
        end
        default: begin
          phase_next        = PH_HUNT;
          digits_left_next  = 4'd0;
          length_acc_next   = '0;
          payload_left_next = '0;
        end
      endcase
    end
  end

  // Advance parser state and result register together
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      phase        <= PH_HUNT;
      digits_left  <= 4'd0;
      length_acc   <= '0;
      payload_left <= '0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        phase        <= phase_next;
        digits_left  <= digits_left_next;
        length_acc   <= length_acc_next;
        payload_left <= payload_left_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      status       <= status_next;
      payload_byte <= data_next;
    end
  end

endmodule

// File: rtl/definite_length_block_parser_core.sv
// A byte accepted is held in the input register, then processed into the
// result register, where its result turns valid and waits to be taken.
// Throughput: one byte per cycle unless out_stall or a register write holds
// the input; the two registers let a new byte enter while a result waits.
// A register write stalls the input in its cycle and the next one while the
// two-stage length product settles. Reset clears the parser to hunting for '#'.
module definite_length_block_parser_core
  import dlbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            rx_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            status,
  output logic [7:0]            payload_byte
);

  dlbp_cfg_t cfg;
  logic      cfg_busy;
  status_t   status_q;

  assign cfg_ready = 1'b1;

  dlbp_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg),
    .busy     (cfg_busy)
  );

  dlbp_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cfg_hold     (cfg_busy),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status_q),
    .payload_byte (payload_byte)
  );

  assign status = status_q;

endmodule

// File: rtl/dlbp_checker.sv
module dlbp_checker
  import dlbp_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       cfg_valid,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] status,
  input logic [7:0] payload_byte
);

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_DROP || status == ST_HEADER || status == ST_DATA ||
                   status == ST_LAST || status == ST_REJECT))
    else $error("status code out of range");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_DATA && status != ST_LAST) |-> payload_byte == 8'h00)
    else $error("payload_byte nonzero outside payload");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(payload_byte)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_no_stall_free: assert property (@(posedge clk) disable iff (rst)
    ((!out_valid || !out_stall) && !cfg_valid && !$past(cfg_valid)) |-> !in_stall)
    else $error("input stalled while result side is free");

endmodule

bind definite_length_block_parser_core dlbp_checker u_dlbp_checker (
  .clk          (clk),
  .rst          (rst),
  .cfg_valid    (cfg_valid),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .payload_byte (payload_byte)
);
